[rtl/core/jet_pkg.sv]
package jet_pkg;

	// number format and field widths
	localparam int FRAC_BITS  = 20;
	localparam int GRID_SIZE  = 64;
	localparam int COORD_W    = 6;
	localparam int IDX_W      = $clog2(GRID_SIZE);
	localparam int CONST_W    = 22;
	localparam int ORIGIN_W   = 23;
	localparam int PITCH_W    = 21;
	localparam int LIMIT_W    = 8;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 23;

	// start point: origin plus index times pitch, two guard bits for sign and carry
	localparam int Z_W    = IDX_W + PITCH_W + 2;
	localparam int PROD_W = 2 * Z_W;
	localparam int SUM_W  = PROD_W + 1;

	localparam int QUEUE_DEPTH = 2;

	// register reset values
	localparam logic [CONST_W-1:0]  CONST_RST  = '0;
	localparam logic [LIMIT_W-1:0]  LIMIT_RST  = LIMIT_W'(32);
	localparam logic [ORIGIN_W-1:0] ORIGIN_RST = ORIGIN_W'(-1572864);
	localparam logic [PITCH_W-1:0]  PITCH_RST  = PITCH_W'(49152);

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_CONST_REAL,
		CFG_CONST_IMAG,
		CFG_ITER_LIMIT,
		CFG_ORIGIN_REAL,
		CFG_ORIGIN_IMAG,
		CFG_PIXEL_PITCH
	} cfg_idx_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_MUL,
		B_STEP,
		B_DONE
	} back_state_t;

	typedef struct packed {
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
	} pixel_t;

	typedef struct packed {
		logic [COORD_W-1:0] out_column;
		logic [COORD_W-1:0] out_row;
		logic [LIMIT_W-1:0] escape_count;
		logic               is_inside;
	} result_t;

	typedef struct packed {
		logic [CFG_ADDR_W-1:0] addr;
		logic [CFG_DATA_W-1:0] wdata;
	} cfg_wr_t;

	typedef struct packed {
		logic [CONST_W-1:0]  const_real;
		logic [CONST_W-1:0]  const_imag;
		logic [LIMIT_W-1:0]  iteration_limit;
		logic [ORIGIN_W-1:0] origin_real;
		logic [ORIGIN_W-1:0] origin_imag;
		logic [PITCH_W-1:0]  pixel_pitch;
	} cfg_t;

	// one mapped pixel waiting for the iteration engine
	typedef struct packed {
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
		logic [Z_W-1:0]     zr;
		logic [Z_W-1:0]     zi;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// grid index of a pixel coordinate
	function automatic logic [IDX_W-1:0] grid_index(input logic [COORD_W-1:0] v);
		return IDX_W'(v % GRID_SIZE);
	endfunction

endpackage

[rtl/core/jet_stream_if.sv]
interface jet_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/jet_front.sv]
module jet_front (
	input  logic          clk,
	input  logic          arst_n,
	jet_stream_if.sink    pixel,
	input  jet_pkg::cfg_t cfg_q,
	input  jet_pkg::qstat_t q_stat,
	output logic          q_push,
	output jet_pkg::job_t q_job
);
	import jet_pkg::*;

	logic                          valid_s1;
	pixel_t                        pix_s1;
	logic [IDX_W-1:0]              xi;
	logic [IDX_W-1:0]              yi;
	logic [IDX_W+PITCH_W-1:0]      xoff;
	logic [IDX_W+PITCH_W-1:0]      yoff;
	logic signed [Z_W-1:0]         zr0;
	logic signed [Z_W-1:0]         zi0;

	// one holding stage, freed when the queue takes the mapped pixel
	assign q_push      = valid_s1 && !q_stat.full;
	assign pixel.ready = !valid_s1 || !q_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel.valid && pixel.ready) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pixel.valid && pixel.ready) begin
			pix_s1 <= pixel.data;
		end
	end

	// map pixel to start point
	always_comb begin
		xi   = grid_index(pix_s1.column);
		yi   = grid_index(pix_s1.row);
		xoff = (IDX_W+PITCH_W)'(xi) * (IDX_W+PITCH_W)'(cfg_q.pixel_pitch);
		yoff = (IDX_W+PITCH_W)'(yi) * (IDX_W+PITCH_W)'(cfg_q.pixel_pitch);
		zr0  = $signed({{(Z_W-ORIGIN_W){cfg_q.origin_real[ORIGIN_W-1]}}, cfg_q.origin_real})
			+ $signed({{(Z_W-IDX_W-PITCH_W){1'b0}}, xoff});
		zi0  = $signed({{(Z_W-ORIGIN_W){cfg_q.origin_imag[ORIGIN_W-1]}}, cfg_q.origin_imag})
			+ $signed({{(Z_W-IDX_W-PITCH_W){1'b0}}, yoff});
		q_job.column = pix_s1.column;
		q_job.row    = pix_s1.row;
		q_job.zr     = zr0;
		q_job.zi     = zi0;
	end

endmodule

[rtl/core/jet_queue.sv]
module jet_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  jet_pkg::job_t   push_job,
	input  logic            pop,
	output jet_pkg::job_t   head_job,
	output jet_pkg::qstat_t stat
);
	import jet_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign stat.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign head_job   = entry_q[rd_ptr_q];

	// pointer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

[rtl/core/jet_back.sv]
module jet_back (
	input  logic            clk,
	input  logic            arst_n,
	input  jet_pkg::cfg_t   cfg_q,
	input  jet_pkg::job_t   head_job,
	input  jet_pkg::qstat_t q_stat,
	output logic            q_pop,
	jet_stream_if.source    result
);
	import jet_pkg::*;

	localparam logic signed [SUM_W-1:0] FOUR = SUM_W'(4) << (2 * FRAC_BITS);

	back_state_t              state_q;
	back_state_t              state_d;
	logic                     load;
	logic                     mul_en;
	logic                     upd;
	logic                     fin;
	logic signed [Z_W-1:0]    zr_q;
	logic signed [Z_W-1:0]    zi_q;
	logic [LIMIT_W-1:0]       cnt_q;
	logic [COORD_W-1:0]       col_q;
	logic [COORD_W-1:0]       row_q;
	logic signed [PROD_W-1:0] rr_q;
	logic signed [PROD_W-1:0] ii_q;
	logic signed [PROD_W-1:0] ri_q;
	logic signed [SUM_W-1:0]  mag_sq;
	logic signed [SUM_W-1:0]  diff;
	logic signed [Z_W-1:0]    cre;
	logic signed [Z_W-1:0]    cim;
	logic signed [Z_W-1:0]    zr_next;
	logic signed [Z_W-1:0]    zi_next;
	logic                     escape;
	logic                     out_valid_q;
	result_t                  out_data_q;

	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

	// escape test and next z from the registered products
	always_comb begin
		mag_sq  = $signed({rr_q[PROD_W-1], rr_q}) + $signed({ii_q[PROD_W-1], ii_q});
		diff    = $signed({rr_q[PROD_W-1], rr_q}) - $signed({ii_q[PROD_W-1], ii_q});
		escape  = (mag_sq >= FOUR);
		cre     = $signed({{(Z_W-CONST_W){cfg_q.const_real[CONST_W-1]}}, cfg_q.const_real});
		cim     = $signed({{(Z_W-CONST_W){cfg_q.const_imag[CONST_W-1]}}, cfg_q.const_imag});
		zr_next = Z_W'(diff >>> FRAC_BITS) + cre;
		zi_next = Z_W'(ri_q >>> (FRAC_BITS - 1)) + cim;
	end

	// sequencer: each iteration passes through a squaring state (B_MUL) and an update state (B_STEP)
	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		load    = 1'b0;
		mul_en  = 1'b0;
		upd     = 1'b0;
		fin     = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (!q_stat.empty) begin
					q_pop   = 1'b1;
					load    = 1'b1;
					state_d = B_MUL;
				end
			end
			B_MUL: begin
				if (cnt_q == cfg_q.iteration_limit) begin
					state_d = B_DONE;
				end else begin
					mul_en  = 1'b1;
					state_d = B_STEP;
				end
			end
			B_STEP: begin
				if (escape) begin
					state_d = B_DONE;
				end else begin
					upd     = 1'b1;
					state_d = B_MUL;
				end
			end
			B_DONE: begin
				if (!out_valid_q || result.ready) begin
					fin     = 1'b1;
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// iteration datapath
	always_ff @(posedge clk) begin
		if (load) begin
			zr_q  <= head_job.zr;
			zi_q  <= head_job.zi;
			col_q <= head_job.column;
			row_q <= head_job.row;
			cnt_q <= '0;
		end else if (upd) begin
			zr_q  <= zr_next;
			zi_q  <= zi_next;
			cnt_q <= cnt_q + 1'b1;
		end
		if (mul_en) begin
			rr_q <= PROD_W'(zr_q) * PROD_W'(zr_q);
			ii_q <= PROD_W'(zi_q) * PROD_W'(zi_q);
			ri_q <= PROD_W'(zr_q) * PROD_W'(zi_q);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			out_data_q.out_column   <= col_q;
			out_data_q.out_row      <= row_q;
			out_data_q.escape_count <= cnt_q;
			out_data_q.is_inside    <= (cnt_q == cfg_q.iteration_limit);
		end
	end

endmodule

[rtl/core/julia_escape_time.sv]
// julia set escape-time engine, one pixel per transaction, one result per pixel
// the back end works on one pixel at a time, iterating on its three-multiplier squaring unit,
// while the front holding stage and the two-entry queue accept further pixels
// reset: arst_n clears control state and restores the register defaults at once
module julia_escape_time (
	input  logic         clk,
	input  logic         arst_n,
	jet_stream_if.sink   pixel,
	jet_stream_if.sink   cfg,
	jet_stream_if.source result
);
	import jet_pkg::*;

	cfg_t   cfg_q;
	logic   q_push;
	logic   q_pop;
	job_t   q_job;
	job_t   head_job;
	qstat_t q_stat;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.const_real      <= CONST_RST;
			cfg_q.const_imag      <= CONST_RST;
			cfg_q.iteration_limit <= LIMIT_RST;
			cfg_q.origin_real     <= ORIGIN_RST;
			cfg_q.origin_imag     <= ORIGIN_RST;
			cfg_q.pixel_pitch     <= PITCH_RST;
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.data.addr))
				CFG_CONST_REAL:  cfg_q.const_real      <= cfg.data.wdata[CONST_W-1:0];
				CFG_CONST_IMAG:  cfg_q.const_imag      <= cfg.data.wdata[CONST_W-1:0];
				CFG_ITER_LIMIT:  cfg_q.iteration_limit <= cfg.data.wdata[LIMIT_W-1:0];
				CFG_ORIGIN_REAL: cfg_q.origin_real     <= cfg.data.wdata[ORIGIN_W-1:0];
				CFG_ORIGIN_IMAG: cfg_q.origin_imag     <= cfg.data.wdata[ORIGIN_W-1:0];
				CFG_PIXEL_PITCH: cfg_q.pixel_pitch     <= cfg.data.wdata[PITCH_W-1:0];
				default: ;
			endcase
		end
	end

	// pixel mapping
	jet_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pixel),
		.cfg_q  (cfg_q),
		.q_stat (q_stat),
		.q_push (q_push),
		.q_job  (q_job)
	);

	// mapped pixels waiting for the iteration engine
	jet_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_job),
		.pop      (q_pop),
		.head_job (head_job),
		.stat     (q_stat)
	);

	// iteration engine and output register
	jet_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_q    (cfg_q),
		.head_job (head_job),
		.q_stat   (q_stat),
		.q_pop    (q_pop),
		.result   (result)
	);

	// queue is never written while full nor read while empty
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("queue read while empty");

	// a delivered count never passes the limit
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.data.escape_count <= cfg_q.iteration_limit))
		else $error("escape count above iteration limit");

endmodule

[tb/sv/tb_julia_escape_time.sv]
`timescale 1ns / 1ps

module tb_julia_escape_time;
	import jet_pkg::*;

	localparam int NUM_DIRECTED    = 38;
	localparam int NUM_PHASES      = 12;
	localparam int PIXELS_PER_VIEW = 140;
	localparam int LONG_HOLD       = 600;
	localparam int SETTLE_CYCLES   = 600;
	localparam int WATCHDOG_LIMIT  = 5000;

	// indexes with no register behind them
	localparam int CFG_UNMAPPED_LO = 6;
	localparam int CFG_UNMAPPED_HI = 7;

	typedef enum bit {STEP_PIXEL, STEP_WRITE} step_kind_t;

	// pixel: arg_a column, arg_b row; write: arg_a index, arg_b data
	typedef struct {
		step_kind_t kind;
		int         arg_a;
		int         arg_b;
		bit         known;
		int         count;
		bit         in_set;
	} dir_step_t;

	logic clk = 1'b0;
	logic arst_n;

	jet_stream_if #(.T(pixel_t))  pixel_ch ();
	jet_stream_if #(.T(cfg_wr_t)) cfg_ch ();
	jet_stream_if #(.T(result_t)) result_ch ();

	julia_escape_time dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pixel_ch),
		.cfg    (cfg_ch),
		.result (result_ch)
	);

	always #5 clk = ~clk;

	// mirror of the register file, at reset values
	longint c_re          = 0;
	longint c_im          = 0;
	longint iter_cap      = 32;
	longint view_re       = -1572864;
	longint view_im       = -1572864;
	longint view_pitch    = 49152;

	result_t awaited_escapes[$];
	int      mismatch_count = 0;
	int      quiet_cycles = 0;
	bit      tx_gaps = 1'b1;
	bit      rx_gaps = 1'b1;
	bit      long_hold_pending = 1'b0;

	dir_step_t directed_steps[NUM_DIRECTED] = '{
		// reset view: corners escape at once, the center is a fixed point
		'{STEP_PIXEL, 0, 0, 1, 0, 0},
		'{STEP_PIXEL, 32, 32, 1, 32, 1},
		'{STEP_PIXEL, 63, 63, 1, 0, 0},
		'{STEP_PIXEL, 63, 0, 1, 0, 0},
		'{STEP_PIXEL, 32, 0, 0, 0, 0},
		'{STEP_PIXEL, 42, 21, 0, 0, 0},
		// writes to unmapped indexes change nothing
		'{STEP_WRITE, CFG_UNMAPPED_LO, 'h7FFFFF, 0, 0, 0},
		'{STEP_WRITE, CFG_UNMAPPED_HI, 0, 0, 0, 0},
		'{STEP_PIXEL, 32, 32, 1, 32, 1},
		// zero limit: no iteration, every pixel counts as inside
		'{STEP_WRITE, CFG_ITER_LIMIT, 0, 0, 0, 0},
		'{STEP_PIXEL, 32, 32, 1, 0, 1},
		'{STEP_PIXEL, 0, 0, 1, 0, 1},
		'{STEP_WRITE, CFG_ITER_LIMIT, 1, 0, 0, 0},
		'{STEP_PIXEL, 32, 32, 1, 1, 1},
		'{STEP_WRITE, CFG_ITER_LIMIT, 255, 0, 0, 0},
		'{STEP_PIXEL, 32, 32, 1, 255, 1},
		// constant at the corners of its range
		'{STEP_WRITE, CFG_CONST_REAL, -2097152, 0, 0, 0},
		'{STEP_WRITE, CFG_CONST_IMAG, 2097151, 0, 0, 0},
		'{STEP_PIXEL, 32, 32, 0, 0, 0},
		'{STEP_PIXEL, 10, 50, 0, 0, 0},
		// c near -0.7885 gives a connected set with long orbits
		'{STEP_WRITE, CFG_CONST_REAL, -826802, 0, 0, 0},
		'{STEP_WRITE, CFG_CONST_IMAG, 0, 0, 0, 0},
		'{STEP_WRITE, CFG_ITER_LIMIT, 64, 0, 0, 0},
		'{STEP_PIXEL, 20, 30, 0, 0, 0},
		'{STEP_PIXEL, 32, 40, 0, 0, 0},
		'{STEP_PIXEL, 44, 32, 0, 0, 0},
		// origin at both ends of its range
		'{STEP_WRITE, CFG_ORIGIN_REAL, -4194304, 0, 0, 0},
		'{STEP_WRITE, CFG_ORIGIN_IMAG, -4194304, 0, 0, 0},
		'{STEP_PIXEL, 0, 0, 1, 0, 0},
		'{STEP_WRITE, CFG_ORIGIN_REAL, 4194303, 0, 0, 0},
		'{STEP_WRITE, CFG_ORIGIN_IMAG, 0, 0, 0, 0},
		'{STEP_WRITE, CFG_PIXEL_PITCH, 0, 0, 0, 0},
		'{STEP_PIXEL, 63, 63, 1, 0, 0},
		// pitch above one: column 1 sits just inside radius 2, column 2 far out
		'{STEP_WRITE, CFG_ORIGIN_REAL, 0, 0, 0, 0},
		'{STEP_WRITE, CFG_PIXEL_PITCH, 2097151, 0, 0, 0},
		'{STEP_PIXEL, 1, 0, 0, 0, 0},
		'{STEP_PIXEL, 2, 0, 1, 0, 0},
		'{STEP_PIXEL, 0, 63, 1, 0, 0}
	};

	// escape-time iteration on the mirrored registers
	function automatic result_t escape_of(input pixel_t px);
		longint  zr, zi, rr, ii, ri, four;
		longint  n;
		result_t r;
		four = longint'(4) <<< (2 * FRAC_BITS);
		zr = view_re + longint'(int'(px.column) % GRID_SIZE) * view_pitch;
		zi = view_im + longint'(int'(px.row) % GRID_SIZE) * view_pitch;
		n = 0;
		while (n < iter_cap) begin
			rr = zr * zr;
			ii = zi * zi;
			ri = zr * zi;
			if (rr + ii >= four)
				break;
			zr = ((rr - ii) >>> FRAC_BITS) + c_re;
			zi = ((2 * ri) >>> FRAC_BITS) + c_im;
			n++;
		end
		r.out_column   = px.column;
		r.out_row      = px.row;
		r.escape_count = n[LIMIT_W-1:0];
		r.is_inside    = (n == iter_cap);
		return r;
	endfunction

	// one register write transaction, mirrored once accepted
	task automatic write_register(input int index, input int value);
		logic signed [CONST_W-1:0]  c_val;
		logic signed [ORIGIN_W-1:0] o_val;
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= '{addr: index[CFG_ADDR_W-1:0], wdata: value[CFG_DATA_W-1:0]};
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		c_val = value[CONST_W-1:0];
		o_val = value[ORIGIN_W-1:0];
		case (index)
			CFG_CONST_REAL:  c_re = c_val;
			CFG_CONST_IMAG:  c_im = c_val;
			CFG_ITER_LIMIT:  iter_cap = value[LIMIT_W-1:0];
			CFG_ORIGIN_REAL: view_re = o_val;
			CFG_ORIGIN_IMAG: view_im = o_val;
			CFG_PIXEL_PITCH: view_pitch = value[PITCH_W-1:0];
			default: ;
		endcase
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// one pixel transaction; valid stays high when the next one follows at once
	task automatic send_pixel(input pixel_t px, input bit known, input int count,
			input bit in_set);
		int      gap;
		result_t want;
		if ($urandom_range(0, 39) == 0)
			tx_gaps = !tx_gaps;
		gap = tx_gaps ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			pixel_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_ch.valid <= 1'b1;
		pixel_ch.data  <= px;
		@(posedge clk);
		while (!pixel_ch.ready)
			@(posedge clk);
		if (known)
			want = '{out_column: px.column, out_row: px.row,
				escape_count: count[LIMIT_W-1:0], is_inside: in_set};
		else
			want = escape_of(px);
		awaited_escapes.push_back(want);
	endtask

	// stop offering pixels and wait for every outstanding result
	task automatic close_stream();
		pixel_ch.valid <= 1'b0;
		@(posedge clk);
		while (awaited_escapes.size() != 0)
			@(posedge clk);
	endtask

	// new register set for one random view
	task automatic program_view(input int flavor);
		case (flavor)
			0: begin
				// overview of the whole set
				write_register(CFG_CONST_REAL, int'($urandom_range(0, 2097151)) - 1048576);
				write_register(CFG_CONST_IMAG, int'($urandom_range(0, 2097151)) - 1048576);
				write_register(CFG_ITER_LIMIT, $urandom_range(1, 64));
				write_register(CFG_ORIGIN_REAL, int'($urandom_range(0, 524288)) - 2097152);
				write_register(CFG_ORIGIN_IMAG, int'($urandom_range(0, 524288)) - 2097152);
				write_register(CFG_PIXEL_PITCH, $urandom_range(16384, 65536));
			end
			1: begin
				// zoomed in somewhere near the center
				write_register(CFG_CONST_REAL, int'($urandom_range(0, 2097151)) - 1048576);
				write_register(CFG_CONST_IMAG, int'($urandom_range(0, 2097151)) - 1048576);
				write_register(CFG_ITER_LIMIT, $urandom_range(16, 128));
				write_register(CFG_ORIGIN_REAL, int'($urandom_range(0, 3145728)) - 1572864);
				write_register(CFG_ORIGIN_IMAG, int'($urandom_range(0, 3145728)) - 1572864);
				write_register(CFG_PIXEL_PITCH, $urandom_range(0, 4096));
			end
			2: begin
				// raw bit patterns, unmapped indexes included
				write_register(CFG_UNMAPPED_LO, $urandom);
				write_register(CFG_CONST_REAL, $urandom);
				write_register(CFG_CONST_IMAG, $urandom);
				write_register(CFG_ITER_LIMIT, $urandom);
				write_register(CFG_ORIGIN_REAL, $urandom);
				write_register(CFG_ORIGIN_IMAG, $urandom);
				write_register(CFG_PIXEL_PITCH, $urandom);
				write_register(CFG_UNMAPPED_HI, $urandom);
			end
			default: begin
				// deepest limit with a small c, so many pixels stay inside
				write_register(CFG_CONST_REAL, int'($urandom_range(0, 524288)) - 262144);
				write_register(CFG_CONST_IMAG, int'($urandom_range(0, 524288)) - 262144);
				write_register(CFG_ITER_LIMIT, 255);
				write_register(CFG_ORIGIN_REAL, int'($urandom_range(0, 524288)) - 2097152);
				write_register(CFG_ORIGIN_IMAG, int'($urandom_range(0, 524288)) - 2097152);
				write_register(CFG_PIXEL_PITCH, $urandom_range(16384, 65536));
			end
		endcase
	endtask

	// compare one result transaction with the oldest prediction
	task automatic check_escape(input result_t got);
		result_t want;
		if (awaited_escapes.size() == 0) begin
			$error("result with nothing awaited: column %0d row %0d count %0d",
				got.out_column, got.out_row, got.escape_count);
			mismatch_count++;
			return;
		end
		want = awaited_escapes.pop_front();
		if (got.out_column !== want.out_column) begin
			$error("out_column expected %0d actual %0d", want.out_column, got.out_column);
			mismatch_count++;
		end
		if (got.out_row !== want.out_row) begin
			$error("out_row expected %0d actual %0d", want.out_row, got.out_row);
			mismatch_count++;
		end
		if (got.escape_count !== want.escape_count) begin
			$error("escape_count expected %0d actual %0d", want.escape_count,
				got.escape_count);
			mismatch_count++;
		end
		if (got.is_inside !== want.is_inside) begin
			$error("is_inside expected %0d actual %0d", want.is_inside, got.is_inside);
			mismatch_count++;
		end
	endtask

	// result side: random stalls, one long hold-off on request
	initial begin : result_sink
		int stall;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 49) == 0)
				rx_gaps = !rx_gaps;
			stall = rx_gaps ? $urandom_range(0, 14) : 0;
			if (long_hold_pending) begin
				long_hold_pending = 1'b0;
				stall = LONG_HOLD;
			end
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!result_ch.valid)
				@(posedge clk);
			check_escape(result_ch.data);
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((pixel_ch.valid && pixel_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
					(result_ch.valid && result_ch.ready))
				quiet_cycles <= 0;
			else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// stimulus: reset, directed table, then random views
	initial begin : stimulus
		pixel_t px;
		bit     streaming;
		arst_n         <= 1'b0;
		pixel_ch.valid <= 1'b0;
		pixel_ch.data  <= '0;
		cfg_ch.valid   <= 1'b0;
		cfg_ch.data    <= '0;
		streaming = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int s = 0; s < NUM_DIRECTED; s++) begin
			if (directed_steps[s].kind == STEP_WRITE) begin
				if (streaming) begin
					close_stream();
					streaming = 1'b0;
				end
				write_register(directed_steps[s].arg_a, directed_steps[s].arg_b);
			end else begin
				px.column = directed_steps[s].arg_a[COORD_W-1:0];
				px.row    = directed_steps[s].arg_b[COORD_W-1:0];
				send_pixel(px, directed_steps[s].known, directed_steps[s].count,
					directed_steps[s].in_set);
				streaming = 1'b1;
			end
		end
		close_stream();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			program_view(ph % 4);
			// back-to-back pixels while the result side holds off
			if (ph == 1) begin
				long_hold_pending = 1'b1;
				tx_gaps = 1'b0;
			end
			for (int k = 0; k < PIXELS_PER_VIEW; k++) begin
				px.column = COORD_W'($urandom_range(0, GRID_SIZE - 1));
				px.row    = COORD_W'($urandom_range(0, GRID_SIZE - 1));
				send_pixel(px, 1'b0, 0, 1'b0);
			end
			close_stream();
		end

		// catch any stray result after the last one
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
